>>> hdl/ast_pkg.sv
package ast_pkg;

    localparam int VALUE_W = 32;
    localparam int MODE_W  = 2;
    localparam int OUT_W   = 7;    // width of position and count_after

    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // control half of the search probe moving down the cell chain
    typedef struct packed {
        logic valid;
        logic hit;
    } ast_probe_ctl_t;

endpackage

>>> hdl/ast_cell.sv
module ast_cell
    import ast_pkg::*;
#(
    parameter int CW  = 7,
    parameter int IDX = 0
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ast_probe_ctl_t      in_ctl,
    input  logic [VALUE_W-1:0]  in_value,
    input  logic [CW-1:0]       in_pos,
    input  logic [VALUE_W-1:0]  in_last,
    input  logic [CW-1:0]       count,
    input  logic                wr_en,
    input  logic [CW-1:0]       wr_idx,
    input  logic [VALUE_W-1:0]  wr_data,
    output ast_probe_ctl_t      out_ctl,
    output logic [VALUE_W-1:0]  out_value,
    output logic [CW-1:0]       out_pos,
    output logic [VALUE_W-1:0]  out_last
);

    logic [VALUE_W-1:0] entry_reg;
    ast_probe_ctl_t     ctl_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [CW-1:0]      pos_reg;
    logic [VALUE_W-1:0] last_reg;
    logic               match;
    logic               is_last;

    // first hit wins; later cells see hit already set
    assign match   = in_ctl.valid && !in_ctl.hit && (CW'(IDX) < count)
                     && (entry_reg == in_value);
    assign is_last = (CW'(IDX + 1) == count);

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_idx == CW'(IDX)))
        begin
            entry_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg.valid <= in_ctl.valid;
            ctl_reg.hit   <= in_ctl.hit || match;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= in_value;
        pos_reg   <= match ? CW'(IDX) : in_pos;
        last_reg  <= is_last ? entry_reg : in_last;
    end

    assign out_ctl   = ctl_reg;
    assign out_value = value_reg;
    assign out_pos   = pos_reg;
    assign out_last  = last_reg;

endmodule

>>> hdl/array_set_table_core.sv
// Items are processed one at a time: s_axis_tready is high only in ST_IDLE, so a new item
// is taken only after the last one has left ST_HOLD. The probe walks the cell chain
// one cell per cycle, the write and count update are applied as the result enters the
// hold registers, and then the output register is loaded; a receiver still holding off the last beat delays that.
// A finished result waits in the output register while the next item is taken.
// Reset (rst_n low, async): count cleared, chain and handshake idle; entries are not cleared.
module array_set_table_core
    import ast_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [0] found, [7:1] position,
                                        // [14:8] count_after, [15] status
);

    // count runs 0..CAPACITY
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] { ST_IDLE, ST_SCAN, ST_HOLD } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic                hold_found_reg, hold_found_next;
    logic [OUT_W-1:0]    hold_pos_reg, hold_pos_next;
    logic [OUT_W-1:0]    hold_cnt_reg, hold_cnt_next;
    logic                hold_status_reg, hold_status_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [15:0]         m_tdata_reg, m_tdata_next;

    // probe chain: index k feeds cell k, index CAPACITY is the tail
    ast_probe_ctl_t      chain_ctl   [CAPACITY+1];
    logic [VALUE_W-1:0]  chain_value [CAPACITY+1];
    logic [CW-1:0]       chain_pos   [CAPACITY+1];
    logic [VALUE_W-1:0]  chain_last  [CAPACITY+1];

    logic                in_beat;
    logic                out_free;
    logic                tail_valid;
    logic                tail_hit;
    logic                wr_en;
    logic [CW-1:0]       wr_idx;
    logic [VALUE_W-1:0]  wr_data;
    logic                res_status;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_tvalid_reg || m_axis_tready;

    // launch: probe not-found position starts at the current count
    assign chain_ctl[0].valid = in_beat;
    assign chain_ctl[0].hit   = 1'b0;
    assign chain_value[0]     = s_axis_tdata;
    assign chain_pos[0]       = count_reg;
    assign chain_last[0]      = '0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            ast_cell #(
                .CW  (CW),
                .IDX (gi)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_ctl    (chain_ctl[gi]),
                .in_value  (chain_value[gi]),
                .in_pos    (chain_pos[gi]),
                .in_last   (chain_last[gi]),
                .count     (count_reg),
                .wr_en     (wr_en),
                .wr_idx    (wr_idx),
                .wr_data   (wr_data),
                .out_ctl   (chain_ctl[gi+1]),
                .out_value (chain_value[gi+1]),
                .out_pos   (chain_pos[gi+1]),
                .out_last  (chain_last[gi+1])
            );
        end
    endgenerate

    assign tail_valid = chain_ctl[CAPACITY].valid;
    assign tail_hit   = chain_ctl[CAPACITY].hit;

    // update at the tail: insert appends at count, delete moves the
    // last entry (picked up by the probe on its way) into the hit slot
    always_comb
    begin
        wr_en      = 1'b0;
        wr_idx     = count_reg;
        wr_data    = chain_value[CAPACITY];
        count_next = count_reg;
        res_status = STATUS_OK;
        if ((state_reg == ST_SCAN) && tail_valid)
        begin
            case (mode_reg)
                MODE_INSERT:
                begin
                    if (!tail_hit)
                    begin
                        if (count_reg < CW'(CAPACITY))
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            res_status = STATUS_FULL;
                        end
                    end
                end
                MODE_DELETE:
                begin
                    if (tail_hit)
                    begin
                        wr_en      = 1'b1;
                        wr_idx     = chain_pos[CAPACITY];
                        wr_data    = chain_last[CAPACITY];
                        count_next = count_reg - CW'(1);
                    end
                end
                default:
                begin
                    // lookup, and the unused code, change nothing
                end
            endcase
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        hold_found_next  = hold_found_reg;
        hold_pos_next    = hold_pos_reg;
        hold_cnt_next    = hold_cnt_reg;
        hold_status_next = hold_status_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;

        if (m_tvalid_reg && m_axis_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    mode_next  = s_axis_tuser;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (tail_valid)
                begin
                    hold_found_next  = tail_hit;
                    hold_pos_next    = OUT_W'(chain_pos[CAPACITY]);
                    hold_cnt_next    = OUT_W'(count_next);
                    hold_status_next = res_status;
                    state_next       = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {hold_status_reg, hold_cnt_reg,
                                     hold_pos_reg, hold_found_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            mode_reg        <= MODE_LOOKUP;
            hold_found_reg  <= 1'b0;
            hold_pos_reg    <= '0;
            hold_cnt_reg    <= '0;
            hold_status_reg <= STATUS_OK;
            m_tvalid_reg    <= 1'b0;
            m_tdata_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            mode_reg        <= mode_next;
            hold_found_reg  <= hold_found_next;
            hold_pos_reg    <= hold_pos_next;
            hold_cnt_reg    <= hold_cnt_next;
            hold_status_reg <= hold_status_next;
            m_tvalid_reg    <= m_tvalid_next;
            m_tdata_reg     <= m_tdata_next;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    // count never exceeds the table size
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("count above capacity");

    // the probe only leaves the chain while a scan is in flight
    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tail_valid |-> (state_reg == ST_SCAN))
        else $error("probe at tail outside scan");

    // count moves only when a scan completes
    a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == ST_SCAN))
        else $error("count changed outside scan completion");

    // an accepted beat starts a scan
    a_beat_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (state_reg == ST_SCAN))
        else $error("accepted beat did not start a scan");

    // a completed scan always goes to the hold stage
    a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tail_valid |=> (state_reg == ST_HOLD))
        else $error("scan result not held");

endmodule
